[hw/rtl/accel_level_trim_calibrator_unit_assert.svh]
// Assertion macros for the accelerometer trim calibrator.
// Both macros sample on the rising edge of clk and are disabled while rst is high.
`ifndef ACCEL_LEVEL_TRIM_CALIBRATOR_UNIT_ASSERT_SVH
`define ACCEL_LEVEL_TRIM_CALIBRATOR_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// A condition that must hold at every edge.
`define ALTC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// A condition that must be followed by another on the next edge.
`define ALTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ALTC_ASSERT(lbl, prop, msg)
`define ALTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

[hw/rtl/altc_pkg.sv]
package altc_pkg;

  // Run lengths of the two averaging passes.
  localparam int unsigned CAL_CYCLES      = 400;
  localparam int unsigned INFLIGHT_CYCLES = 50;

  // Fixed widths of samples, sums and counters.
  localparam int unsigned AXIS_W    = 16;
  localparam int unsigned NUM_AXES  = 3;
  localparam int unsigned GSUM_W    = 25;
  localparam int unsigned ISUM_W    = 22;
  localparam int unsigned GCNT_W    = 9;
  localparam int unsigned ICNT_W    = 6;
  localparam int unsigned ONE_G_W   = 14;
  localparam int unsigned CMD_W     = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [ONE_G_W-1:0] ONE_G_RESET = ONE_G_W'(256);

  // Reciprocals for exact truncating division of magnitudes below 2**width.
  localparam int unsigned CAL_SHIFT = GSUM_W + $clog2(CAL_CYCLES);
  localparam logic [63:0] CAL_RECIP =
    ((64'd1 << CAL_SHIFT) + 64'(CAL_CYCLES) - 64'd1) / 64'(CAL_CYCLES);
  localparam int unsigned INF_SHIFT = ISUM_W + $clog2(INFLIGHT_CYCLES);
  localparam logic [63:0] INF_RECIP =
    ((64'd1 << INF_SHIFT) + 64'(INFLIGHT_CYCLES) - 64'd1) / 64'(INFLIGHT_CYCLES);

  typedef logic signed [AXIS_W-1:0] axis_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_SAMPLE     = 3'd0,
    CMD_GROUND_CAL = 3'd1,
    CMD_ARM_FLIGHT = 3'd2,
    CMD_SAVE_FLIGHT = 3'd3,
    CMD_LOAD_TRIMS = 3'd4
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ONE_G       = 1'b0,
    REG_INFLIGHT_EN = 1'b1
  } cfg_reg_t;

  // Per-result status flags.
  typedef struct packed {
    logic inflight_measured;
    logic angle_trim_reset;
    logic save_request;
    logic calibrating;
  } status_t;

  // Ground average: n / CAL_CYCLES truncated toward zero, low 16 bits.
  function automatic axis_t cal_avg(logic signed [GSUM_W:0] n);
    logic                  neg;
    logic [GSUM_W-1:0]     mag;
    logic [2*GSUM_W:0]     prod;
    logic [AXIS_W-1:0]     q;
    neg  = n[GSUM_W];
    mag  = neg ? GSUM_W'(-n) : GSUM_W'(n);
    prod = mag * CAL_RECIP[GSUM_W:0];
    q    = prod[CAL_SHIFT +: AXIS_W];
    return neg ? axis_t'(AXIS_W'(0) - q) : axis_t'(q);
  endfunction

  // In-flight average: n / INFLIGHT_CYCLES truncated toward zero, low 16 bits.
  function automatic axis_t inf_avg(logic signed [ISUM_W-1:0] n);
    logic                  neg;
    logic [ISUM_W-1:0]     mag;
    logic [2*ISUM_W:0]     prod;
    logic [AXIS_W-1:0]     q;
    neg  = n[ISUM_W-1];
    mag  = neg ? ISUM_W'(-n) : ISUM_W'(n);
    prod = mag * INF_RECIP[ISUM_W:0];
    q    = prod[INF_SHIFT +: AXIS_W];
    return neg ? axis_t'(AXIS_W'(0) - q) : axis_t'(q);
  endfunction

endpackage

[hw/rtl/accel_level_trim_calibrator_unit.sv]
// Channel  | Direction | Payload
// ---------+-----------+--------------------------------------------------
// s_*      | in        | tuser: cmd; tdata: sample_x, sample_y, sample_z
// m_*      | out       | tdata: out_x/y/z, trim_x/y/z_now; tuser: flags
// cfg_*    | in        | cfg_index selects one_g or inflight_enable
//
// One item is accepted per cycle while s_tready is high; each result is registered before it is offered.
// The work runs in one pass between the input register and the result register.
// Reset (synchronous) clears counters, sums and trims and sets one_g to 256.
// When m_tready is low the result holds, one more item is held in the input
// register, and then s_tready drops until the result is taken.
`include "accel_level_trim_calibrator_unit_assert.svh"

module accel_level_trim_calibrator_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // Fields from bit 0: sample_x[15:0], sample_y[31:16], sample_z[47:32].
  input  logic [47:0]                    s_tdata,
  // Fields from bit 0: cmd[2:0].
  input  logic [altc_pkg::CMD_W-1:0]     s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // Fields from bit 0: out_x, out_y, out_z, trim_x_now, trim_y_now, trim_z_now,
  // 16 bits each.
  output logic [95:0]                    m_tdata,
  // Fields from bit 0: calibrating, save_request, angle_trim_reset, inflight_measured.
  output logic [3:0]                     m_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [altc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [altc_pkg::ONE_G_W-1:0]   cfg_data
);
  import altc_pkg::*;

  // Configuration registers.
  logic [ONE_G_W-1:0] one_g;
  logic               inflight_enable;

  // Input register.
  logic  in_valid;
  cmd_t  in_cmd;
  axis_t in_s [NUM_AXES];

  // Calibration state.
  logic [GCNT_W-1:0]        ground_count, ground_count_next;
  logic signed [GSUM_W-1:0] ground_sum [NUM_AXES];
  logic signed [GSUM_W-1:0] ground_sum_next [NUM_AXES];
  logic [ICNT_W-1:0]        inflight_count, inflight_count_next;
  logic signed [ISUM_W-1:0] inflight_sum [NUM_AXES];
  logic signed [ISUM_W-1:0] inflight_sum_next [NUM_AXES];
  axis_t                    saved_trims [NUM_AXES];
  axis_t                    saved_trims_next [NUM_AXES];
  axis_t                    trims [NUM_AXES];
  axis_t                    trims_next [NUM_AXES];

  // Result register.
  axis_t   res_out [NUM_AXES];
  axis_t   res_trim [NUM_AXES];
  status_t res_status;

  // Single-pass datapath signals.
  axis_t                    s_eff [NUM_AXES];
  axis_t                    out_next [NUM_AXES];
  logic signed [GSUM_W-1:0] gsum_base [NUM_AXES];
  logic signed [ISUM_W-1:0] isum_base [NUM_AXES];
  status_t                  status_next;
  logic                     advance;

  // With an item held, the result register loads whenever it is empty or being drained.
  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      one_g           <= ONE_G_RESET;
      inflight_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ONE_G:       one_g <= cfg_data;
        REG_INFLIGHT_EN: inflight_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd <= cmd_t'(s_tuser);
      for (int a = 0; a < NUM_AXES; a++) begin
        in_s[a] <= axis_t'(s_tdata[a*AXIS_W +: AXIS_W]);
      end
    end
  end

  // Command decode and trim arithmetic for the item in the input register.
  always_comb begin
    ground_count_next   = ground_count;
    inflight_count_next = inflight_count;
    status_next         = '0;
    for (int a = 0; a < NUM_AXES; a++) begin
      ground_sum_next[a]   = ground_sum[a];
      inflight_sum_next[a] = inflight_sum[a];
      saved_trims_next[a]  = saved_trims[a];
      trims_next[a]        = trims[a];
      s_eff[a]             = in_s[a];
      out_next[a]          = '0;
      gsum_base[a] = (ground_count == GCNT_W'(CAL_CYCLES)) ? '0 : ground_sum[a];
      isum_base[a] = (inflight_count == ICNT_W'(INFLIGHT_CYCLES)) ? '0 : inflight_sum[a];
    end

    unique case (in_cmd)
      CMD_SAMPLE: begin
        // Ground pass runs first and zeroes the sample it absorbs.
        if (ground_count != '0) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            ground_sum_next[a] = gsum_base[a] + GSUM_W'(s_eff[a]);
            s_eff[a]           = '0;
            trims_next[a]      = '0;
          end
          if (ground_count == GCNT_W'(1)) begin
            for (int a = 0; a < NUM_AXES; a++) begin
              trims_next[a] = cal_avg($signed((GSUM_W+1)'(ground_sum_next[a])
                                      + (GSUM_W+1)'(CAL_CYCLES / 2)));
            end
            trims_next[2] = trims_next[2] - $signed({2'b00, one_g});
            status_next.save_request     = 1'b1;
            status_next.angle_trim_reset = 1'b1;
          end
          ground_count_next = ground_count - GCNT_W'(1);
        end
        // In-flight pass sees what the ground pass left.
        if (inflight_enable) begin
          if (inflight_count == ICNT_W'(INFLIGHT_CYCLES)) begin
            for (int a = 0; a < NUM_AXES; a++) begin
              saved_trims_next[a] = trims_next[a];
            end
          end
          if (inflight_count != '0) begin
            for (int a = 0; a < NUM_AXES; a++) begin
              inflight_sum_next[a] = isum_base[a] + ISUM_W'(s_eff[a]);
              s_eff[a]             = '0;
              trims_next[a]        = '0;
            end
            if (inflight_count == ICNT_W'(1)) begin
              status_next.inflight_measured = 1'b1;
              for (int a = 0; a < NUM_AXES; a++) begin
                trims_next[a] = saved_trims[a];
              end
            end
            inflight_count_next = inflight_count - ICNT_W'(1);
          end
        end
        for (int a = 0; a < NUM_AXES; a++) begin
          out_next[a] = s_eff[a] - trims_next[a];
        end
      end
      CMD_GROUND_CAL: begin
        ground_count_next = GCNT_W'(CAL_CYCLES);
      end
      CMD_ARM_FLIGHT: begin
        if (inflight_enable) begin
          inflight_count_next = ICNT_W'(INFLIGHT_CYCLES);
        end
      end
      CMD_SAVE_FLIGHT: begin
        if (inflight_enable) begin
          for (int a = 0; a < NUM_AXES; a++) begin
            trims_next[a] = inf_avg(inflight_sum[a]);
          end
          trims_next[2] = trims_next[2] - $signed({2'b00, one_g});
          status_next.save_request     = 1'b1;
          status_next.angle_trim_reset = 1'b1;
        end
      end
      CMD_LOAD_TRIMS: begin
        for (int a = 0; a < NUM_AXES; a++) begin
          trims_next[a] = in_s[a];
        end
      end
      default: ;
    endcase

    status_next.calibrating = (ground_count_next != '0) || (inflight_count_next != '0);
  end

  // State update, one item per advance.
  always_ff @(posedge clk) begin
    if (rst) begin
      ground_count   <= '0;
      inflight_count <= '0;
      for (int a = 0; a < NUM_AXES; a++) begin
        ground_sum[a]   <= '0;
        inflight_sum[a] <= '0;
        saved_trims[a]  <= '0;
        trims[a]        <= '0;
      end
    end else if (advance) begin
      ground_count   <= ground_count_next;
      inflight_count <= inflight_count_next;
      for (int a = 0; a < NUM_AXES; a++) begin
        ground_sum[a]   <= ground_sum_next[a];
        inflight_sum[a] <= inflight_sum_next[a];
        saved_trims[a]  <= saved_trims_next[a];
        trims[a]        <= trims_next[a];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_status <= status_next;
      for (int a = 0; a < NUM_AXES; a++) begin
        res_out[a]  <= out_next[a];
        res_trim[a] <= trims_next[a];
      end
    end
  end

  assign m_tdata = {res_trim[2], res_trim[1], res_trim[0],
                    res_out[2], res_out[1], res_out[0]};
  assign m_tuser = {res_status.inflight_measured, res_status.angle_trim_reset,
                    res_status.save_request, res_status.calibrating};

  // Checks on counters, the pipeline and the status flag.
  `ALTC_ASSERT(a_ground_count_range, ground_count <= GCNT_W'(CAL_CYCLES), "ground count out of range")
  `ALTC_ASSERT(a_inflight_count_range, inflight_count <= ICNT_W'(INFLIGHT_CYCLES), "in-flight count out of range")
  `ALTC_ASSERT_NEXT(a_result_loaded, advance, m_tvalid, "result register not loaded")
  `ALTC_ASSERT_NEXT(a_input_held, in_valid && !advance, in_valid && $stable(in_cmd), "input register lost its item")
  `ALTC_ASSERT_NEXT(a_cal_flag, advance, m_tuser[0] == ((ground_count != '0) || (inflight_count != '0)), "calibrating flag mismatch")

endmodule
